// ===== design/tsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types, codes and constants of the TGA stream pixel parser.
// Depends on nothing; every other design file imports it.
package tsp_pkg;

    localparam int HEADER_BYTES = 18;
    localparam int FIFO_DEPTH   = 4;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_DATA   = 3'd1;
    localparam logic [2:0] ST_COLORMAP  = 3'd2;
    localparam logic [2:0] ST_GREY      = 3'd3;
    localparam logic [2:0] ST_RLE       = 3'd4;
    localparam logic [2:0] ST_UNDEFINED = 3'd5;
    localparam logic [2:0] ST_BAD_DEPTH = 3'd6;
    localparam logic [2:0] ST_SHORT     = 3'd7;

    localparam logic [7:0] TYPE_NONE      = 8'd0;
    localparam logic [7:0] TYPE_CMAP      = 8'd1;
    localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
    localparam logic [7:0] TYPE_GREY      = 8'd3;
    localparam logic [7:0] TYPE_RLE_CMAP  = 8'd9;
    localparam logic [7:0] TYPE_RLE_TRUE  = 8'd10;
    localparam logic [7:0] TYPE_RLE_GREY  = 8'd11;

    localparam logic [7:0] DEPTH_24 = 8'd24;
    localparam logic [7:0] DEPTH_32 = 8'd32;

    localparam logic [4:0] HB_IDLEN    = 5'd0;
    localparam logic [4:0] HB_TYPE     = 5'd2;
    localparam logic [4:0] HB_CMLEN_LO = 5'd5;
    localparam logic [4:0] HB_CMLEN_HI = 5'd6;
    localparam logic [4:0] HB_CMENT    = 5'd7;
    localparam logic [4:0] HB_XO_LO    = 5'd8;
    localparam logic [4:0] HB_XO_HI    = 5'd9;
    localparam logic [4:0] HB_YO_LO    = 5'd10;
    localparam logic [4:0] HB_YO_HI    = 5'd11;
    localparam logic [4:0] HB_W_LO     = 5'd12;
    localparam logic [4:0] HB_W_HI     = 5'd13;
    localparam logic [4:0] HB_H_LO     = 5'd14;
    localparam logic [4:0] HB_H_HI     = 5'd15;
    localparam logic [4:0] HB_DEPTH    = 5'd16;
    localparam logic [4:0] HB_LAST     = 5'(HEADER_BYTES - 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [15:0] x_origin;
        logic [15:0] y_origin;
        logic [7:0]  pixel_depth;
        logic [7:0]  descriptor;
        logic [2:0]  status;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_event;

    function automatic logic [2:0] classify(input logic [7:0] img_type,
                                            input logic [7:0] depth);
        logic [2:0] st;
        unique case (img_type) inside
            TYPE_NONE:      st = ST_NO_DATA;
            TYPE_CMAP:      st = ST_COLORMAP;
            TYPE_TRUECOLOR: st = (depth == DEPTH_24 || depth == DEPTH_32) ? ST_OK
                                                                          : ST_BAD_DEPTH;
            TYPE_GREY:      st = ST_GREY;
            TYPE_RLE_CMAP, TYPE_RLE_TRUE, TYPE_RLE_GREY: st = ST_RLE;
            default:        st = ST_UNDEFINED;
        endcase
        return st;
    endfunction

endpackage
`default_nettype wire

// ===== design/tsp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Front end: header decode, skip of ID and color map, grouping of pixel bytes.
// Emits at most one result event per accepted byte. Depends on tsp_pkg.
module tsp_front
    import tsp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_accept,
    input  wire t_item  i_item,
    output t_event      o_event
);

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_SKIP   = 4'b0010,
        PH_PIXELS = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_hidx, n_hidx;
    logic [1:0]  r_chan, n_chan;
    logic [21:0] r_skip, n_skip;
    logic [31:0] r_pix_left, n_pix_left;
    logic [23:0] r_part, n_part;
    logic        r_bpp4, n_bpp4;

    logic [7:0]  r_idlen, r_type, r_cment, r_depth;
    logic [15:0] r_cmlen, r_xo, r_yo, r_w, r_h;

    logic [8:0]  w_cment_sum;
    logic [5:0]  w_units;
    logic [21:0] w_map, w_skip;
    logic [31:0] w_prod;
    logic [2:0]  w_status, w_hdr_st;
    logic        w_pix_nz, w_pix_done;
    logic [23:0] w_part;
    logic [7:0]  w_byte;
    logic        w_eof;

    assign w_byte      = i_item.data_byte;
    assign w_eof       = i_item.end_of_file;
    assign w_cment_sum = {1'b0, r_cment} + 9'd7;
    assign w_units     = w_cment_sum[8:3];
    assign w_map       = {6'b0, r_cmlen} * {16'b0, w_units};
    assign w_skip      = {14'b0, r_idlen} + w_map;
    assign w_prod      = {16'b0, r_w} * {16'b0, r_h};
    assign w_pix_nz    = (r_w != 16'd0) && (r_h != 16'd0);
    assign w_status    = classify(r_type, r_depth);
    assign w_hdr_st    = (w_status == ST_OK && w_pix_nz && w_eof) ? ST_SHORT : w_status;
    assign w_pix_done  = r_bpp4 ? (r_chan == 2'd3) : (r_chan == 2'd2);

    always_comb begin
        w_part = r_part;
        case (r_chan)
            2'd0:    w_part[7:0]   = w_byte;
            2'd1:    w_part[15:8]  = w_byte;
            2'd2:    w_part[23:16] = w_byte;
            default: w_part        = r_part;
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_hidx     = r_hidx;
        n_chan     = r_chan;
        n_skip     = r_skip;
        n_pix_left = r_pix_left;
        n_part     = r_part;
        n_bpp4     = r_bpp4;
        o_event    = '0;
        if (i_accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    n_hidx = r_hidx + 5'd1;
                    if (r_hidx == HB_LAST) begin
                        o_event.valid            = 1'b1;
                        o_event.res.kind         = KIND_HEADER;
                        o_event.res.image_width  = r_w;
                        o_event.res.image_height = r_h;
                        o_event.res.x_origin     = r_xo;
                        o_event.res.y_origin     = r_yo;
                        o_event.res.pixel_depth  = r_depth;
                        o_event.res.descriptor   = w_byte;
                        o_event.res.status       = w_hdr_st;
                        n_bpp4                   = (r_depth == DEPTH_32);
                        n_pix_left               = w_prod;
                        n_skip                   = w_skip;
                        n_phase                  = PH_DONE;
                        if (w_status == ST_OK && w_pix_nz) begin
                            n_phase = (w_skip != 22'd0) ? PH_SKIP : PH_PIXELS;
                        end
                    end else if (w_eof) begin
                        o_event.valid      = 1'b1;
                        o_event.res.kind   = KIND_ERROR;
                        o_event.res.status = ST_SHORT;
                    end
                end
                PH_SKIP: begin
                    n_skip = r_skip - 22'd1;
                    if (r_skip == 22'd1) begin
                        n_phase = PH_PIXELS;
                    end
                    if (w_eof) begin
                        o_event.valid      = 1'b1;
                        o_event.res.kind   = KIND_ERROR;
                        o_event.res.status = ST_SHORT;
                    end
                end
                PH_PIXELS: begin
                    n_part = w_part;
                    n_chan = r_chan + 2'd1;
                    if (w_pix_done) begin
                        o_event.valid     = 1'b1;
                        o_event.res.kind  = KIND_PIXEL;
                        o_event.res.blue  = w_part[7:0];
                        o_event.res.green = w_part[15:8];
                        o_event.res.red   = w_part[23:16];
                        o_event.res.alpha = r_bpp4 ? w_byte : 8'hFF;
                        n_chan            = 2'd0;
                        n_pix_left        = r_pix_left - 32'd1;
                        if (r_pix_left == 32'd1) begin
                            n_phase = PH_DONE;
                        end
                    end else if (w_eof) begin
                        o_event.valid      = 1'b1;
                        o_event.res.kind   = KIND_ERROR;
                        o_event.res.status = ST_SHORT;
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
            if (w_eof) begin
                n_phase = PH_HEADER;
                n_hidx  = 5'd0;
                n_chan  = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_hidx  <= 5'd0;
            r_chan  <= 2'd0;
        end else begin
            r_phase <= n_phase;
            r_hidx  <= n_hidx;
            r_chan  <= n_chan;
        end
    end

    always_ff @(posedge i_clk) begin
        r_skip     <= n_skip;
        r_pix_left <= n_pix_left;
        r_part     <= n_part;
        r_bpp4     <= n_bpp4;
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && r_phase == PH_HEADER) begin
            unique case (r_hidx)
                HB_IDLEN:    r_idlen       <= w_byte;
                HB_TYPE:     r_type        <= w_byte;
                HB_CMLEN_LO: r_cmlen[7:0]  <= w_byte;
                HB_CMLEN_HI: r_cmlen[15:8] <= w_byte;
                HB_CMENT:    r_cment       <= w_byte;
                HB_XO_LO:    r_xo[7:0]     <= w_byte;
                HB_XO_HI:    r_xo[15:8]    <= w_byte;
                HB_YO_LO:    r_yo[7:0]     <= w_byte;
                HB_YO_HI:    r_yo[15:8]    <= w_byte;
                HB_W_LO:     r_w[7:0]      <= w_byte;
                HB_W_HI:     r_w[15:8]     <= w_byte;
                HB_H_LO:     r_h[7:0]      <= w_byte;
                HB_H_HI:     r_h[15:8]     <= w_byte;
                HB_DEPTH:    r_depth       <= w_byte;
                default:     r_idlen       <= r_idlen;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== design/tsp_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Result queue between the parser front end and the output ports.
// Holds FIFO_DEPTH results; depends on tsp_pkg.
module tsp_fifo
    import tsp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_wr,
    input  wire t_result i_wdata,
    input  wire logic    i_rd,
    output t_result      o_rdata,
    output logic         o_empty,
    output logic         o_full
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_result         r_mem [FIFO_DEPTH];
    logic [AW-1:0]   r_wp, n_wp;
    logic [AW-1:0]   r_rp, n_rp;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            w_rd;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(FIFO_DEPTH));
    assign o_rdata = r_mem[r_rp];
    assign w_rd    = i_rd && !o_empty;

    always_comb begin
        n_wp  = i_wr ? r_wp + AW'(1) : r_wp;
        n_rp  = w_rd ? r_rp + AW'(1) : r_rp;
        n_cnt = r_cnt + CW'(i_wr) - CW'(w_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule
`default_nettype wire

// ===== design/tga_stream_pixel_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the TGA stream pixel parser: front end plus result queue.
// Each result is registered into the result queue and shows on the output at its head.
// Throughput: one byte per cycle while full is low; the header's size products are
// formed in the cycle of the last header byte, so no stall follows the header.
// full rises only when the four-entry result queue is full.
// Reset: synchronous; clears the parser state and empties the queue at once.
module tga_stream_pixel_parser_core
    import tsp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    push,
    output logic         full,
    input  wire t_item   i_item,
    output logic         empty,
    input  wire logic    pop,
    output t_result      o_result
);

    t_event w_event;
    logic   w_accept;

    assign w_accept = push && !full;

    tsp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_item  (i_item),
        .o_event (w_event)
    );

    tsp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_event.valid),
        .i_wdata (w_event.res),
        .i_rd    (pop),
        .o_rdata (o_result),
        .o_empty (empty),
        .o_full  (full)
    );

endmodule
`default_nettype wire

// ===== design/tsp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks for the TGA stream pixel parser, bound to the top level.
// Depends on tsp_pkg and tga_stream_pixel_parser_core.
module tsp_checker
    import tsp_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    push,
    input wire logic    full,
    input wire logic    empty,
    input wire logic    pop,
    input wire t_result o_result
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("queue not empty after reset");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && !push) |=> empty)
        else $error("result appeared without an input transaction");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (full && !pop) |=> full)
        else $error("full dropped without an output transaction");

    a_kind_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.kind == KIND_HEADER || o_result.kind == KIND_PIXEL ||
                    o_result.kind == KIND_ERROR))
        else $error("unknown result kind");

    a_pixel_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.kind == KIND_PIXEL) |->
            (o_result.status == ST_OK && o_result.image_width == 16'd0 &&
             o_result.pixel_depth == 8'd0))
        else $error("pixel result carries header fields or status");

endmodule

bind tga_stream_pixel_parser_core tsp_checker u_tsp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_result(o_result)
);
`default_nettype wire
